FILE: sv/pool2d_pkg.sv
// Shared types, constants and defaults of the 2-D pooling block.
`default_nettype none
package pool2d_pkg;

  localparam int SampleBits     = 16;
  localparam int OutIdxBits     = 8;
  localparam int CfgDimBits     = 9;
  localparam int CfgWinBits     = 3;
  localparam int ApbAddrBits    = 5;
  localparam int ApbDataBits    = 32;

  localparam int DefMaxWindow   = 4;
  localparam int DefMaxWidth    = 256;
  localparam int DefMaxHeight   = 256;

  localparam logic KindMax      = 1'b0;
  localparam logic KindMean     = 1'b1;

  typedef enum logic [2:0] {
    RegPoolKind   = 3'd0,
    RegGlobalMode = 3'd1,
    RegWindowSize = 3'd2,
    RegStepSize   = 3'd3,
    RegMapHeight  = 3'd4,
    RegMapWidth   = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StDivStart,
    StDivWait,
    StEmit
  } state_e;

  typedef struct packed {
    logic                  pool_kind;
    logic                  global_mode;
    logic [CfgWinBits-1:0] window_size;
    logic [CfgWinBits-1:0] step_size;
    logic [CfgDimBits-1:0] map_height;
    logic [CfgDimBits-1:0] map_width;
  } cfg_t;

endpackage
`default_nettype wire

FILE: sv/pool2d_ifs.sv
// Valid/ready channel interfaces for samples in and pooled results out.
`default_nettype none
interface pool2d_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pool2d_pkg::SampleBits-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface pool2d_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pool2d_pkg::SampleBits-1:0] pooled;
  logic [pool2d_pkg::OutIdxBits-1:0]     out_row;
  logic [pool2d_pkg::OutIdxBits-1:0]     out_col;
  logic                                  map_done;
  modport source (output valid, output pooled, output out_row, output out_col,
                  output map_done, input ready);
  modport sink (input valid, input pooled, input out_row, input out_col,
                input map_done, output ready);
endinterface
`default_nettype wire

FILE: sv/pool2d_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pool2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: sv/pool2d_cfg.sv
// APB-style configuration register file of the pooling block.
`default_nettype none
module pool2d_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pool2d_pkg::ApbAddrBits-1:0]  paddr,
  input  wire logic [pool2d_pkg::ApbDataBits-1:0]  pwdata,
  output logic      [pool2d_pkg::ApbDataBits-1:0]  prdata,
  output logic                                     pready,
  output pool2d_pkg::cfg_t                         cfg_o,
  output logic                                     restart_o
);
  import pool2d_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;
  logic hit;
  reg_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d  = cfg_q;
    hit    = 1'b1;
    prdata = '0;
    unique case (idx)
      RegPoolKind: begin
        prdata = ApbDataBits'(cfg_q.pool_kind);
        cfg_d.pool_kind = pwdata[0];
      end
      RegGlobalMode: begin
        prdata = ApbDataBits'(cfg_q.global_mode);
        cfg_d.global_mode = pwdata[0];
      end
      RegWindowSize: begin
        prdata = ApbDataBits'(cfg_q.window_size);
        cfg_d.window_size = pwdata[CfgWinBits-1:0];
      end
      RegStepSize: begin
        prdata = ApbDataBits'(cfg_q.step_size);
        cfg_d.step_size = pwdata[CfgWinBits-1:0];
      end
      RegMapHeight: begin
        prdata = ApbDataBits'(cfg_q.map_height);
        cfg_d.map_height = pwdata[CfgDimBits-1:0];
      end
      RegMapWidth: begin
        prdata = ApbDataBits'(cfg_q.map_width);
        cfg_d.map_width = pwdata[CfgDimBits-1:0];
      end
      default: hit = 1'b0;
    endcase
  end

  assign restart_o = wr && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_kind   <= KindMax;
      cfg_q.global_mode <= 1'b0;
      cfg_q.window_size <= CfgWinBits'(2);
      cfg_q.step_size   <= CfgWinBits'(2);
      cfg_q.map_height  <= CfgDimBits'(8);
      cfg_q.map_width   <= CfgDimBits'(8);
    end else if (restart_o) begin
      cfg_q <= cfg_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pool2d_div.sv
// Serial restoring signed divider, one quotient bit per cycle.
`default_nettype none
module pool2d_div #(
  parameter int NumBits = 33,
  parameter int DenBits = 17,
  parameter int QuoBits = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0]        den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [QuoBits-1:0]             quo_o
);
  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic               neg_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DenBits:0]   trial;
  logic [NumBits-1:0] quo_s;

  assign trial  = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quo_s  = neg_q ? (~quo_q + NumBits'(1)) : quo_q;
  assign quo_o  = quo_s[QuoBits-1:0];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (busy_o) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CntBits'(1);
      done_d = cnt_q == CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntBits'(NumBits);
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NumBits-1];
      quo_q <= num_i[NumBits-1] ? (~num_i + NumBits'(1)) : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pooling_2d_max_average_top.sv
// Top level of the 2-D max and average pooling block.
// Samples of one feature map enter in raster order on smp_i (valid/ready);
// pooled results leave on res_o with output row, column and a map_done flag
// on the last result of a map. Registers are written through the APB port
// (pool kind, global mode, window, step, map height and width); a write to
// one of these registers restarts the current map.
// Each sample is written to a line memory of MAX_WINDOW rows as it is taken.
// A sample that completes no window leaves the block ready for the next one.
// One that completes a window starts a scan of the line memory, one read per
// cycle over the k*k entries (k the window side), then a drain and the
// hand-over of the result; a mean adds a serial divide. A map in global mode
// is reduced on the fly; only its last sample costs the hand-over or divide.
// One result is held in an output register; the block keeps taking samples
// while it waits, and stalls on the next result until the receiver takes it.
// Reset is asynchronous and active low: registers return to their reset
// values, counters to the start of a map. No clearing pass is needed.
`default_nettype none
module pooling_2d_max_average_top #(
  parameter int MAX_WINDOW = pool2d_pkg::DefMaxWindow,
  parameter int MAX_WIDTH  = pool2d_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = pool2d_pkg::DefMaxHeight
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  pool2d_sample_if.sink                            smp_i,
  pool2d_result_if.source                          res_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pool2d_pkg::ApbAddrBits-1:0]  paddr,
  input  wire logic [pool2d_pkg::ApbDataBits-1:0]  pwdata,
  output logic      [pool2d_pkg::ApbDataBits-1:0]  prdata,
  output logic                                     pready
);
  import pool2d_pkg::*;

  localparam int SB      = SampleBits;
  localparam int HDW     = $clog2(MAX_HEIGHT + 1);
  localparam int WDW     = $clog2(MAX_WIDTH + 1);
  localparam int KW      = $clog2(MAX_WINDOW + 1);
  localparam int SLW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int Depth   = MAX_WINDOW * MAX_WIDTH;
  localparam int AW      = $clog2(Depth);
  localparam int SumBits = SB + $clog2(MAX_HEIGHT * MAX_WIDTH) + 1;
  localparam int DVW     = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_WINDOW * MAX_WINDOW + 1);

  cfg_t cfg;
  logic restart;

  pool2d_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  logic [KW-1:0]         k_c;
  logic [CfgWinBits-1:0] st_c;
  logic [HDW-1:0]        h_c;
  logic [WDW-1:0]        w_c;

  assign k_c  = (cfg.window_size == '0) ? KW'(1) :
                (int'(cfg.window_size) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(cfg.window_size);
  assign st_c = (cfg.step_size == '0) ? CfgWinBits'(1) : cfg.step_size;
  assign h_c  = (cfg.map_height == '0) ? HDW'(1) :
                (int'(cfg.map_height) > MAX_HEIGHT) ? HDW'(MAX_HEIGHT) : HDW'(cfg.map_height);
  assign w_c  = (cfg.map_width == '0) ? WDW'(1) :
                (int'(cfg.map_width) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(cfg.map_width);

  state_e state_q, state_d;

  logic [HDW-1:0]        row_q, row_d;
  logic [WDW-1:0]        col_q, col_d;
  logic [SLW-1:0]        slot_q, slot_d;
  logic [CfgWinBits-1:0] rph_q, rph_d, cph_q, cph_d;
  logic [OutIdxBits-1:0] ri_q, ri_d, ci_q, ci_d;
  logic signed [SumBits-1:0] sum_q, sum_n;
  logic signed [SB-1:0]      max_q, max_n;

  logic signed [SumBits-1:0] acc_q;
  logic signed [SB-1:0]      amx_q;
  logic [DVW-1:0]            dvs_q;
  logic [WDW-1:0]            tc_q;
  logic [SLW-1:0]            srow_q;
  logic [KW-1:0]             rc_q, cc_q;
  logic                      rdv_q;
  logic [OutIdxBits-1:0]     rs_row_q, rs_col_q;
  logic                      rs_done_q;

  logic                  ov_q;
  logic signed [SB-1:0]  pooled_q;
  logic [OutIdxBits-1:0] orow_q, ocol_q;
  logic                  odone_q;

  logic accept, last, fire, col_end;
  logic signed [SB-1:0] s;
  logic signed [SB-1:0] most_neg;
  logic [SLW-1:0] slot0;
  logic scan_end;
  logic ram_re, div_start, emit, div_busy, div_done;
  logic [AW-1:0] waddr, raddr;
  logic [SB-1:0] rdata;
  logic [SB-1:0] quo;
  logic signed [SB-1:0] rd_s;

  assign most_neg = {1'b1, {(SB-1){1'b0}}};
  assign s        = smp_i.sample;
  assign accept   = smp_i.valid && smp_i.ready;
  assign col_end  = col_q == (w_c - WDW'(1));
  assign last     = (row_q == (h_c - HDW'(1))) && col_end;
  assign fire     = !cfg.global_mode && (int'(k_c) <= int'(h_c)) && (int'(k_c) <= int'(w_c))
                    && (int'(row_q) + 1 >= int'(k_c)) && (int'(col_q) + 1 >= int'(k_c))
                    && (rph_q == '0) && (cph_q == '0);
  assign sum_n    = sum_q + SumBits'(s);
  assign max_n    = (s > max_q) ? s : max_q;
  assign slot0    = SLW'((int'(slot_q) + MAX_WINDOW - (int'(k_c) - 1)) >= MAX_WINDOW ?
                         (int'(slot_q) + MAX_WINDOW - (int'(k_c) - 1)) - MAX_WINDOW :
                         (int'(slot_q) + MAX_WINDOW - (int'(k_c) - 1)));
  assign scan_end = (rc_q == (k_c - KW'(1))) && (cc_q == (k_c - KW'(1)));
  assign waddr    = AW'(int'(slot_q) * MAX_WIDTH + int'(col_q));
  assign raddr    = AW'(int'(srow_q) * MAX_WIDTH + int'(tc_q) + int'(cc_q));
  assign rd_s     = rdata;

  pool2d_ram #(.Width(SB), .Depth(Depth)) u_line (
    .clk_i,
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (s),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pool2d_div #(.NumBits(SumBits), .DenBits(DVW), .QuoBits(SB)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (dvs_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          priority if (cfg.global_mode && last) begin
            state_d = (cfg.pool_kind == KindMean) ? StDivStart : StEmit;
          end else if (fire) begin
            state_d = StScan;
          end
        end
      end
      StScan:     if (scan_end) state_d = StDrain;
      StDrain:    state_d = (cfg.pool_kind == KindMean) ? StDivStart : StEmit;
      StDivStart: state_d = StDivWait;
      StDivWait:  if (div_done) state_d = StEmit;
      StEmit:     if (!ov_q || res_o.ready) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    smp_i.ready = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      StIdle:     smp_i.ready = 1'b1;
      StScan:     ram_re = 1'b1;
      StDivStart: div_start = 1'b1;
      StEmit:     emit = !ov_q || res_o.ready;
      default:    ;
    endcase
  end

  // map position and window phase
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    rph_d  = rph_q;
    cph_d  = cph_q;
    ri_d   = ri_q;
    ci_d   = ci_q;
    if (restart) begin
      row_d  = '0;
      col_d  = '0;
      slot_d = '0;
      rph_d  = '0;
      cph_d  = '0;
      ri_d   = '0;
      ci_d   = '0;
    end else if (accept) begin
      priority if (last) begin
        row_d  = '0;
        col_d  = '0;
        slot_d = '0;
      end else if (col_end) begin
        col_d  = '0;
        row_d  = row_q + HDW'(1);
        slot_d = (int'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + SLW'(1);
      end else begin
        col_d  = col_q + WDW'(1);
      end
      if (int'(col_d) + 1 == int'(k_c)) begin
        cph_d = '0;
        ci_d  = '0;
      end else begin
        cph_d = (cph_q + CfgWinBits'(1) == st_c) ? '0 : cph_q + CfgWinBits'(1);
        ci_d  = (cph_q + CfgWinBits'(1) == st_c) ? ci_q + OutIdxBits'(1) : ci_q;
      end
      if (int'(row_d) + 1 == int'(k_c)) begin
        rph_d = '0;
        ri_d  = '0;
      end else if (row_d != row_q) begin
        rph_d = (rph_q + CfgWinBits'(1) == st_c) ? '0 : rph_q + CfgWinBits'(1);
        ri_d  = (rph_q + CfgWinBits'(1) == st_c) ? ri_q + OutIdxBits'(1) : ri_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      rph_q   <= '0;
      cph_q   <= '0;
      ri_q    <= '0;
      ci_q    <= '0;
      sum_q   <= '0;
      max_q   <= most_neg;
      rdv_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      slot_q  <= slot_d;
      rph_q   <= rph_d;
      cph_q   <= cph_d;
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      rdv_q   <= ram_re;
      if (restart || (accept && last)) begin
        sum_q <= '0;
        max_q <= most_neg;
      end else if (accept) begin
        sum_q <= sum_n;
        max_q <= max_n;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // window set-up, scan and accumulate
  always_ff @(posedge clk_i) begin
    if (accept) begin
      srow_q <= slot0;
      tc_q   <= WDW'(int'(col_q) + 1 - int'(k_c));
      rc_q   <= '0;
      cc_q   <= '0;
      if (cfg.global_mode) begin
        acc_q     <= sum_n;
        amx_q     <= max_n;
        dvs_q     <= DVW'(h_c) * DVW'(w_c);
        rs_row_q  <= '0;
        rs_col_q  <= '0;
        rs_done_q <= 1'b1;
      end else begin
        acc_q     <= '0;
        amx_q     <= most_neg;
        dvs_q     <= DVW'(k_c) * DVW'(k_c);
        rs_row_q  <= ri_q;
        rs_col_q  <= ci_q;
        rs_done_q <= (int'(row_q) + int'(st_c) >= int'(h_c))
                     && (int'(col_q) + int'(st_c) >= int'(w_c));
      end
    end else begin
      if (ram_re) begin
        if (cc_q == (k_c - KW'(1))) begin
          cc_q   <= '0;
          rc_q   <= rc_q + KW'(1);
          srow_q <= (int'(srow_q) == MAX_WINDOW - 1) ? '0 : srow_q + SLW'(1);
        end else begin
          cc_q <= cc_q + KW'(1);
        end
      end
      if (rdv_q) begin
        acc_q <= acc_q + SumBits'(rd_s);
        if (rd_s > amx_q) begin
          amx_q <= rd_s;
        end
      end
    end
    if (emit) begin
      pooled_q <= (cfg.pool_kind == KindMean) ? quo : amx_q;
      orow_q   <= rs_row_q;
      ocol_q   <= rs_col_q;
      odone_q  <= rs_done_q;
    end
  end

  assign res_o.valid    = ov_q;
  assign res_o.pooled   = pooled_q;
  assign res_o.out_row  = orow_q;
  assign res_o.out_col  = ocol_q;
  assign res_o.map_done = odone_q;

`ifndef SYNTHESIS
  a_row_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < int'(h_c)) && (int'(col_q) < int'(w_c)))
    else $error("position counter outside the map");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == StDivWait))
    else $error("divider running outside its wait state");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && ov_q && !res_o.ready) |=> (state_q == StEmit))
    else $error("result dropped while output register was full");
`endif
endmodule
`default_nettype wire
